### design/fhp_pkg.sv
package fhp_pkg;

    localparam int HASH_W      = 32;
    localparam int PART_W      = 31;
    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811c_9dc5;
    localparam logic [HASH_W-1:0] FNV_MULT  = 32'h0100_0193;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } back_state_t;

    function automatic logic [HASH_W-1:0] fnv_step(
        input logic [HASH_W-1:0] hash,
        input logic [BYTE_W-1:0] data
    );
        logic [HASH_W-1:0] mixed;
        mixed = hash ^ {{(HASH_W-BYTE_W){1'b0}}, data};
        return mixed * FNV_MULT;
    endfunction

endpackage

### design/fhp_front.sv
module fhp_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // key_byte
    input  logic                      s_tuser,   // has_byte
    input  logic                      s_tlast,   // last_byte
    input  logic                      q_full,
    output logic                      q_push,
    output logic [fhp_pkg::HASH_W-1:0] q_data
);
    import fhp_pkg::*;

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic              accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        hash_next = s_tuser ? fnv_step(hash_reg, s_tdata) : hash_reg;
    end

    assign q_push = accept && s_tlast;
    assign q_data = hash_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
        end
        else if (accept)
        begin
            hash_reg <= s_tlast ? FNV_BASIS : hash_next;
        end
    end

endmodule

### design/fhp_queue.sv
module fhp_queue #(
    parameter int DEPTH = fhp_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [fhp_pkg::HASH_W-1:0] push_data,
    output logic                       full,
    input  logic                       pop,
    output logic [fhp_pkg::HASH_W-1:0] pop_data,
    output logic                       empty
);
    import fhp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [HASH_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("Queue push while full.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Queue count exceeds depth.");

endmodule

### design/fhp_back.sv
module fhp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic [fhp_pkg::PART_W-1:0]  cfg_data,
    input  logic                        q_empty,
    input  logic [fhp_pkg::HASH_W-1:0]  q_data,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 m_tdata    // hash_value, partition_index, pad
);
    import fhp_pkg::*;

    localparam int STEP_W = $clog2(HASH_W);

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [PART_W-1:0] divisor_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] shift_reg;
    logic [PART_W-1:0] rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic [HASH_W-1:0] trial;
    logic [HASH_W-1:0] diff;
    logic              load;

    always_comb
    begin
        trial = {rem_reg, shift_reg[HASH_W-1]};
        diff  = trial - {1'b0, divisor_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (m_tready)
                begin
                    state_next = q_empty ? BK_IDLE : BK_DIV;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid = (state_reg == BK_OUT);
        load     = !q_empty && ((state_reg == BK_IDLE) || (m_tvalid && m_tready));
        q_pop    = load;
        m_tdata  = {1'b0, rem_reg, hash_reg};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hash_reg  <= q_data;
            shift_reg <= q_data;
            rem_reg   <= '0;
            step_reg  <= STEP_W'(HASH_W - 1);
        end
        else if (state_reg == BK_DIV)
        begin
            shift_reg <= {shift_reg[HASH_W-2:0], 1'b0};
            rem_reg   <= (trial >= {1'b0, divisor_reg}) ? diff[PART_W-1:0]
                                                        : trial[PART_W-1:0];
            step_reg  <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            divisor_reg <= PART_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && (cfg_data != '0))
            begin
                divisor_reg <= cfg_data;
            end
        end
    end

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        divisor_reg != '0)
        else $error("Partition divisor is zero.");

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_OUT) |-> (rem_reg < divisor_reg))
        else $error("Remainder not below divisor.");

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV && step_reg != '0) |=> (state_reg == BK_DIV))
        else $error("Division left before its last step.");

endmodule

### design/fnv1a_hash_partitioner_core.sv
// FNV-1a key hasher and partitioner.
// Key bytes enter on the s_* stream, one byte per request; s_tuser marks a request
// that carries a byte, and s_tlast marks the final request of a key. A request with
// s_tlast and no byte closes an empty key. Bytes are taken at one per cycle while the queue is not full.
// On the last request the 32-bit hash goes into a small queue and the running hash
// returns to the offset basis, so the next key may follow in the next cycle.
// Behind the queue a bit-serial divider forms the hash modulo the partition count;
// one result appears on m_tvalid once the division of its hash is done. The divider takes
// the next hash from the queue only after that result is accepted on m_tready, so the
// divider sets the sustained key rate.
// m_tdata holds the hash in bits 31:0 and the partition index in bits 62:32.
// When the receiver stalls, the result holds on m_tdata, the queue fills, and
// s_tready drops only once the queue is full.
// The partition count is written on cfg_valid; a write of zero is ignored. Write
// it only while no key is in flight. Reset sets the count to one, empties the
// queue, and returns the running hash to the offset basis.
module fnv1a_hash_partitioner_core #(
    parameter int QUEUE_DEPTH = fhp_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // key_byte
    input  logic                       s_tuser,   // has_byte
    input  logic                       s_tlast,   // last_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [63:0]                m_tdata,   // hash_value, partition_index, pad
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [fhp_pkg::PART_W-1:0] cfg_data
);
    import fhp_pkg::*;

    logic              q_push;
    logic [HASH_W-1:0] q_push_data;
    logic              q_full;
    logic              q_pop;
    logic [HASH_W-1:0] q_pop_data;
    logic              q_empty;

    assign cfg_ready = 1'b1;

    fhp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    fhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    fhp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
